FILE: hw/rtl/ppsm_pkg.sv
// shared constants and types for the plot point to screen mapper
package ppsm_pkg;

    localparam int DATA_W      = 32;
    localparam int PLOT_SPAN   = 127;
    localparam int TOP_ROW     = 32;
    localparam int QUOT_W      = $clog2(PLOT_SPAN + 1);
    localparam int PROD_W      = DATA_W + QUOT_W;
    localparam int ROW_W       = $clog2(TOP_ROW + PLOT_SPAN + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W      = 4;

    typedef enum logic [1:0] {
        REG_MIN_X = 2'd0,
        REG_MAX_X = 2'd1,
        REG_MIN_Y = 2'd2,
        REG_MAX_Y = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] min_x;
        logic signed [DATA_W-1:0] max_x;
        logic signed [DATA_W-1:0] min_y;
        logic signed [DATA_W-1:0] max_y;
    } window_t;

    typedef struct packed {
        logic              is_bar;
        logic              last;
        logic [DATA_W-1:0] num_x;
        logic [DATA_W-1:0] den_x;
        logic [DATA_W-1:0] num_y;
        logic [DATA_W-1:0] den_y;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic              is_bar;
        logic              last;
        logic [PROD_W-1:0] rem_x;
        logic [PROD_W-1:0] rem_y;
        logic [DATA_W-1:0] den_x;
        logic [DATA_W-1:0] den_y;
        logic [QUOT_W-1:0] q_x;
        logic [QUOT_W-1:0] q_y;
    } div_t;

endpackage

FILE: hw/rtl/ppsm_if.sv
// point and pixel channel interfaces
interface ppsm_point_if;
    logic                             valid;
    logic                             ready;
    logic                             req_type;
    logic signed [ppsm_pkg::DATA_W-1:0] point_x;
    logic signed [ppsm_pkg::DATA_W-1:0] point_y;
    logic                             batch_end;

    modport source (output valid, req_type, point_x, point_y, batch_end, input ready);
    modport sink (input valid, req_type, point_x, point_y, batch_end, output ready);
endinterface

interface ppsm_pixel_if;
    logic                             valid;
    logic                             ready;
    logic [ppsm_pkg::QUOT_W-1:0]      screen_column;
    logic [ppsm_pkg::ROW_W-1:0]       screen_row;
    logic [ppsm_pkg::QUOT_W-1:0]      bar_length;
    logic                             is_bar;
    logic                             batch_end_out;

    modport source (output valid, screen_column, screen_row, bar_length, is_bar,
                    batch_end_out, input ready);
    modport sink (input valid, screen_column, screen_row, bar_length, is_bar,
                  batch_end_out, output ready);
endinterface

FILE: hw/rtl/ppsm_regs.sv
// apb window registers
module ppsm_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [ppsm_pkg::DATA_W-1:0]   pwdata,
    output logic [ppsm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output ppsm_pkg::window_t             window
);

    ppsm_pkg::window_t  win_reg;
    ppsm_pkg::reg_idx_t idx;
    logic               wr_en;

    assign idx    = ppsm_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign window = win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.min_x <= '0;
            win_reg.max_x <= ppsm_pkg::DATA_W'(ppsm_pkg::PLOT_SPAN);
            win_reg.min_y <= '0;
            win_reg.max_y <= ppsm_pkg::DATA_W'(ppsm_pkg::PLOT_SPAN);
        end
        else if (wr_en)
        begin
            case (idx)
                ppsm_pkg::REG_MIN_X: win_reg.min_x <= pwdata;
                ppsm_pkg::REG_MAX_X: win_reg.max_x <= pwdata;
                ppsm_pkg::REG_MIN_Y: win_reg.min_y <= pwdata;
                ppsm_pkg::REG_MAX_Y: win_reg.max_y <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ppsm_pkg::REG_MIN_X: prdata = win_reg.min_x;
            ppsm_pkg::REG_MAX_X: prdata = win_reg.max_x;
            ppsm_pkg::REG_MIN_Y: prdata = win_reg.min_y;
            ppsm_pkg::REG_MAX_Y: prdata = win_reg.max_y;
            default:             prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/ppsm_front.sv
// accepts points, drops those outside the window, forms numerators and spans
module ppsm_front (
    input  ppsm_pkg::window_t        window,
    input  ppsm_pkg::queue_status_t  qstat,
    ppsm_point_if.sink               point_in,
    output logic                     push,
    output ppsm_pkg::work_t          push_word
);

    logic                              in_window;
    logic signed [ppsm_pkg::DATA_W:0]  num_x;
    logic signed [ppsm_pkg::DATA_W:0]  den_x;
    logic signed [ppsm_pkg::DATA_W:0]  num_y;
    logic signed [ppsm_pkg::DATA_W:0]  den_y;

    assign point_in.ready = !qstat.full;

    assign in_window = (point_in.point_x >= window.min_x) && (point_in.point_x <= window.max_x)
                    && (point_in.point_y >= window.min_y) && (point_in.point_y <= window.max_y);

    // differences are non-negative and fit 32 bits once the point is in the window
    assign num_x = 33'(point_in.point_x) - 33'(window.min_x);
    assign den_x = 33'(window.max_x) - 33'(window.min_x);
    assign num_y = 33'(window.max_y) - 33'(point_in.point_y);
    assign den_y = 33'(window.max_y) - 33'(window.min_y);

    assign push = point_in.valid && point_in.ready && in_window;

    always_comb
    begin
        push_word.is_bar = point_in.req_type;
        push_word.last   = point_in.batch_end;
        push_word.num_x  = num_x[ppsm_pkg::DATA_W-1:0];
        push_word.den_x  = den_x[ppsm_pkg::DATA_W-1:0];
        push_word.num_y  = num_y[ppsm_pkg::DATA_W-1:0];
        push_word.den_y  = den_y[ppsm_pkg::DATA_W-1:0];
    end

endmodule

FILE: hw/rtl/ppsm_queue.sv
// short queue between front and back
module ppsm_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  ppsm_pkg::work_t          push_word,
    input  logic                     pop,
    output ppsm_pkg::work_t          head_word,
    output ppsm_pkg::queue_status_t  qstat
);

    ppsm_pkg::work_t                mem_reg [ppsm_pkg::QUEUE_DEPTH];
    logic [ppsm_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [ppsm_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [ppsm_pkg::QPTR_W:0]      count_reg;
    logic [ppsm_pkg::QPTR_W:0]      count_next;

    assign qstat.full  = (count_reg == (ppsm_pkg::QPTR_W+1)'(ppsm_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_word   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: hw/rtl/ppsm_back.sv
// scaling pipeline: product stage, one quotient bit per stage, pixel word out
module ppsm_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ppsm_pkg::work_t          head_word,
    input  ppsm_pkg::queue_status_t  qstat,
    output logic                     pop,
    ppsm_pixel_if.source             pixel_out
);

    localparam int NSTAGE = ppsm_pkg::QUOT_W + 1;

    ppsm_pkg::div_t  st_reg [NSTAGE];
    logic            vld_reg [NSTAGE];
    logic            advance;
    ppsm_pkg::div_t  last_st;

    // all stages move together whenever the last one can drain
    assign advance = !vld_reg[NSTAGE-1] || pixel_out.ready;
    assign pop     = advance && !qstat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTAGE; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            vld_reg[0] <= !qstat.empty;
            for (int i = 1; i < NSTAGE; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // product stage
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0].is_bar <= head_word.is_bar;
            st_reg[0].last   <= head_word.last;
            st_reg[0].rem_x  <= ppsm_pkg::PROD_W'(ppsm_pkg::PLOT_SPAN)
                              * ppsm_pkg::PROD_W'(head_word.num_x);
            st_reg[0].rem_y  <= ppsm_pkg::PROD_W'(ppsm_pkg::PLOT_SPAN)
                              * ppsm_pkg::PROD_W'(head_word.num_y);
            st_reg[0].den_x  <= head_word.den_x;
            st_reg[0].den_y  <= head_word.den_y;
            st_reg[0].q_x    <= '0;
            st_reg[0].q_y    <= '0;
        end
    end

    // restoring steps, most significant quotient bit first
    for (genvar s = 1; s < NSTAGE; s++)
    begin : g_step
        localparam int BIT = ppsm_pkg::QUOT_W - s;

        logic [ppsm_pkg::PROD_W-1:0] sub_x;
        logic [ppsm_pkg::PROD_W-1:0] sub_y;
        logic                        take_x;
        logic                        take_y;
        ppsm_pkg::div_t              st_next;

        assign sub_x  = ppsm_pkg::PROD_W'(st_reg[s-1].den_x) << BIT;
        assign sub_y  = ppsm_pkg::PROD_W'(st_reg[s-1].den_y) << BIT;
        // a zero span gives quotient zero
        assign take_x = (st_reg[s-1].den_x != '0) && (st_reg[s-1].rem_x >= sub_x);
        assign take_y = (st_reg[s-1].den_y != '0) && (st_reg[s-1].rem_y >= sub_y);

        always_comb
        begin
            st_next          = st_reg[s-1];
            st_next.rem_x    = take_x ? st_reg[s-1].rem_x - sub_x : st_reg[s-1].rem_x;
            st_next.rem_y    = take_y ? st_reg[s-1].rem_y - sub_y : st_reg[s-1].rem_y;
            st_next.q_x[BIT] = take_x;
            st_next.q_y[BIT] = take_y;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                st_reg[s] <= st_next;
            end
        end
    end

    assign last_st = st_reg[NSTAGE-1];

    assign pixel_out.valid         = vld_reg[NSTAGE-1];
    assign pixel_out.screen_column = last_st.q_x;
    assign pixel_out.screen_row    = ppsm_pkg::ROW_W'(ppsm_pkg::TOP_ROW)
                                   + ppsm_pkg::ROW_W'(last_st.q_y);
    assign pixel_out.bar_length    = last_st.is_bar
                                   ? ppsm_pkg::QUOT_W'(ppsm_pkg::PLOT_SPAN) - last_st.q_y
                                   : '0;
    assign pixel_out.is_bar        = last_st.is_bar;
    assign pixel_out.batch_end_out = last_st.last;

endmodule

FILE: hw/rtl/plot_point_to_screen_mapper.sv
// Plot point to screen mapper: maps data points inside the programmed window onto a
// 128 by 128 pixel plot area with its top row at row 32. A point word is accepted every
// cycle while the four-word queue behind the window check has room; points outside the
// window are accepted and give no pixel word. The queue entry of a point is written at
// the accepting edge, the product stage takes it from the queue head as the pipeline
// advances, and then one stage per quotient bit of the 7-bit column and row divisions
// forms its pixel word. The pipeline issues one pixel word per cycle while the sink keeps
// ready high. The window registers are written over apb and should only change while no
// point is in flight.
module plot_point_to_screen_mapper (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppsm_pkg::ADDR_W-1:0]   paddr,
    input  logic [ppsm_pkg::DATA_W-1:0]   pwdata,
    output logic [ppsm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    ppsm_point_if.sink                    point_in,
    ppsm_pixel_if.source                  pixel_out
);

    ppsm_pkg::window_t        window;
    ppsm_pkg::queue_status_t  qstat;
    ppsm_pkg::work_t          push_word;
    ppsm_pkg::work_t          head_word;
    logic                     push;
    logic                     pop;

    ppsm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .window  (window)
    );

    ppsm_front u_front (
        .window    (window),
        .qstat     (qstat),
        .point_in  (point_in),
        .push      (push),
        .push_word (push_word)
    );

    ppsm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .head_word (head_word),
        .qstat     (qstat)
    );

    ppsm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_word (head_word),
        .qstat     (qstat),
        .pop       (pop),
        .pixel_out (pixel_out)
    );

endmodule
